// ----- hw/rtl/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types and step codes for the temperature and pressure compensation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int StepW = 4;

    // temperature sequence
    localparam logic [StepW-1:0] T_V1   = 4'd0;
    localparam logic [StepW-1:0] T_SQ   = 4'd1;
    localparam logic [StepW-1:0] T_V2   = 4'd2;
    localparam logic [StepW-1:0] T_FINE = 4'd3;
    localparam logic [StepW-1:0] T_OUT  = 4'd4;

    // pressure sequence
    localparam logic [StepW-1:0] P_V1   = 4'd0;
    localparam logic [StepW-1:0] P_SQ   = 4'd1;
    localparam logic [StepW-1:0] P_V2A  = 4'd2;
    localparam logic [StepW-1:0] P_V2B  = 4'd3;
    localparam logic [StepW-1:0] P_V2C  = 4'd4;
    localparam logic [StepW-1:0] P_V1A  = 4'd5;
    localparam logic [StepW-1:0] P_V1B  = 4'd6;
    localparam logic [StepW-1:0] P_DVS  = 4'd7;
    localparam logic [StepW-1:0] P_NUM  = 4'd8;
    localparam logic [StepW-1:0] P_QUOT = 4'd9;
    localparam logic [StepW-1:0] P_W1A  = 4'd10;
    localparam logic [StepW-1:0] P_W1B  = 4'd11;
    localparam logic [StepW-1:0] P_W2   = 4'd12;
    localparam logic [StepW-1:0] P_OUT  = 4'd13;

    // register indexes
    localparam logic [1:0] REG_TEMP      = 2'd0;
    localparam logic [1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [1:0] REG_PRESS_P9  = 2'd3;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] DIVS_OFFSET  = 32'd32768;
    localparam logic [31:0] ADC_FULL     = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] ROUND_HALF   = 32'd128;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
    localparam logic [31:0] TEMP_SCALE   = 32'd5;

    typedef struct packed {
        logic             load;
        logic             run;
        logic             div_run;
        logic [StepW-1:0] step;
    } tpc_cmd_t;

    typedef struct packed {
        logic kind;
        logic div_done;
        logic div_zero;
    } tpc_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpc_ctrl
// sequencer that steps the datapath through one compensation transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_ctrl
    import tpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire tpc_sts_t sts,
    output tpc_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run   = 1'b1;
                step_next = step_reg + 1'b1;
                if (sts.kind == KIND_TEMP)
                begin
                    if (step_reg == T_OUT)
                        state_next = S_OUT;
                end
                else if (step_reg == P_NUM)
                begin
                    state_next = sts.div_zero ? S_OUT : S_DIV;
                end
                else if (step_reg == P_OUT)
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                cmd.div_run = 1'b1;
                if (sts.div_done)
                    state_next = S_RUN;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_datapath.sv -----
// ----------------------------------------------------------------------------
// tpc_datapath
// coefficient registers, shared 32x32 multiplier and radix-2 divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_datapath
    import tpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_kind,
    input  wire logic [23:0] in_raw,
    input  wire tpc_cmd_t    cmd,
    output tpc_sts_t         sts,
    output logic             out_kind,
    output logic [31:0]      out_temp,
    output logic [31:0]      out_press
);

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction

    logic [47:0] tc_reg;
    logic [63:0] pl_reg, ph_reg;
    logic [15:0] p9_reg;
    logic [31:0] fine_reg, fine_next;
    logic        kind_reg;
    logic [19:0] adc_reg;
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next, rd_reg, rd_next;
    logic [31:0] q_reg, q_next, rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        dbl_reg, dbl_next;
    logic [31:0] temp_reg, temp_next, press_reg, press_next;

    logic [31:0] ma, mb, prod, num, adc32, t1;
    logic [32:0] rem_sh;
    logic        ge;

    assign adc32 = {12'd0, adc_reg};
    assign t1    = {16'd0, tc_reg[15:0]};
    assign prod  = ma * mb;
    assign num   = prod;

    assign rem_sh = {rem_reg, q_reg[31]};
    assign ge     = rem_sh >= {1'b0, rd_reg};

    assign sts.kind     = kind_reg;
    assign sts.div_zero = (rd_reg == '0);
    assign sts.div_done = cmd.div_run && (cnt_reg == 5'd31);

    assign out_kind  = kind_reg;
    assign out_temp  = temp_reg;
    assign out_press = press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg   <= '0;
            pl_reg   <= '0;
            ph_reg   <= '0;
            p9_reg   <= '0;
            fine_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TEMP:     tc_reg <= cfg_data[47:0];
                    REG_PRESS_LO: pl_reg <= cfg_data;
                    REG_PRESS_HI: ph_reg <= cfg_data;
                    REG_PRESS_P9: p9_reg <= cfg_data[15:0];
                    default:      p9_reg <= p9_reg;
                endcase
            end
            fine_reg <= fine_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            adc_reg  <= in_raw[23:4];
        end
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rc_reg    <= rc_next;
        rd_reg    <= rd_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        dbl_reg   <= dbl_next;
        temp_reg  <= temp_next;
        press_reg <= press_next;
    end

    always_comb
    begin
        ma         = '0;
        mb         = '0;
        fine_next  = fine_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rc_next    = rc_reg;
        rd_next    = rd_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dbl_next   = dbl_reg;
        temp_next  = temp_reg;
        press_next = press_reg;

        if (cmd.div_run)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (ge)
            begin
                rem_next = rem_sh[31:0] - rd_reg;
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
        end
        else if (cmd.run && kind_reg == KIND_TEMP)
        begin
            case (cmd.step)
                T_V1:
                begin
                    ma      = {15'd0, adc_reg[19:3]} - (t1 << 1);
                    mb      = sx(tc_reg[31:16]);
                    ra_next = asr(prod, 5'd11);
                end
                T_SQ:
                begin
                    ma      = {16'd0, adc_reg[19:4]} - t1;
                    mb      = ma;
                    rb_next = asr(prod, 5'd12);
                end
                T_V2:
                begin
                    ma      = rb_reg;
                    mb      = sx(tc_reg[47:32]);
                    rb_next = asr(prod, 5'd14);
                end
                T_FINE:
                begin
                    fine_next = ra_reg + rb_reg;
                end
                T_OUT:
                begin
                    ma         = fine_reg;
                    mb         = TEMP_SCALE;
                    temp_next  = asr(prod + ROUND_HALF, 5'd8);
                    press_next = '0;
                end
                default:
                begin
                    ma = '0;
                end
            endcase
        end
        else if (cmd.run)
        begin
            case (cmd.step)
                P_V1:
                begin
                    ra_next = asr(fine_reg, 5'd1) - FINE_OFFSET;
                end
                P_SQ:
                begin
                    ma      = asr(ra_reg, 5'd2);
                    mb      = ma;
                    rb_next = prod;
                end
                P_V2A:
                begin
                    ma      = asr(rb_reg, 5'd11);
                    mb      = sx(ph_reg[31:16]);
                    rc_next = prod;
                end
                P_V2B:
                begin
                    ma      = ra_reg;
                    mb      = sx(ph_reg[15:0]);
                    rc_next = rc_reg + (prod << 1);
                end
                P_V2C:
                begin
                    rc_next = asr(rc_reg, 5'd2) + (sx(pl_reg[63:48]) << 16);
                end
                P_V1A:
                begin
                    ma      = sx(pl_reg[47:32]);
                    mb      = asr(rb_reg, 5'd13);
                    rd_next = asr(prod, 5'd3);
                end
                P_V1B:
                begin
                    ma      = sx(pl_reg[31:16]);
                    mb      = ra_reg;
                    rd_next = asr(rd_reg + asr(prod, 5'd1), 5'd18);
                end
                P_DVS:
                begin
                    ma      = DIVS_OFFSET + rd_reg;
                    mb      = {16'd0, pl_reg[15:0]};
                    rd_next = asr(prod, 5'd15);
                end
                P_NUM:
                begin
                    ma       = (ADC_FULL - adc32) - asr(rc_reg, 5'd12);
                    mb       = PRESS_SCALE;
                    dbl_next = (num >= SIGN_BIT);
                    q_next   = (num >= SIGN_BIT) ? num : (num << 1);
                    rem_next = '0;
                    cnt_next = '0;
                    if (rd_reg == '0)
                    begin
                        temp_next  = '0;
                        press_next = '0;
                    end
                end
                P_QUOT:
                begin
                    rb_next = dbl_reg ? (q_reg << 1) : q_reg;
                end
                P_W1A:
                begin
                    ma      = {3'd0, rb_reg[31:3]};
                    mb      = ma;
                    ra_next = {13'd0, prod[31:13]};
                end
                P_W1B:
                begin
                    ma      = sx(p9_reg);
                    mb      = ra_reg;
                    ra_next = asr(prod, 5'd12);
                end
                P_W2:
                begin
                    ma      = {2'd0, rb_reg[31:2]};
                    mb      = sx(ph_reg[63:48]);
                    rc_next = asr(prod, 5'd13);
                end
                P_OUT:
                begin
                    temp_next  = '0;
                    press_next = rb_reg + asr(ra_reg + rc_reg + sx(ph_reg[47:32]), 5'd4);
                end
                default:
                begin
                    ma = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/temp_pressure_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// temp_pressure_compensation_unit
// integer compensation of raw barometric sensor readings
// ----------------------------------------------------------------------------
// One reading is handled at a time. A temperature transaction runs five
// sequencer steps (four of them on the shared 32x32 multiplier) before its
// result is offered. A pressure transaction runs fourteen steps (ten on the
// multiplier) with the radix-2 divider between steps P_NUM and P_QUOT; when
// the divisor comes out zero, the divider and the later steps are skipped
// and a zero result is offered after P_NUM. The next reading is accepted in
// the cycle after the result is taken.
// Coefficients must be written through the cfg port only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module temp_pressure_compensation_unit
    import tpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // raw_reading
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // temperature_centi, pressure_pa
    output logic             m_tuser,   // kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    tpc_cmd_t    cmd;
    tpc_sts_t    sts;
    logic [31:0] out_temp, out_press;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {out_press, out_temp};

    tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_raw    (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_kind  (m_tuser),
        .out_temp  (out_temp),
        .out_press (out_press)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tpc_checker.sv -----
// ----------------------------------------------------------------------------
// tpc_checker
// port-level checks on the compensation unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one transaction in flight
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("not busy after accept");

    // unused field is zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser ? (m_tdata[31:0] == 32'd0) : (m_tdata[63:32] == 32'd0)))
        else $error("unused result field not zero");

endmodule

bind temp_pressure_compensation_unit tpc_checker u_tpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/temp_pressure_compensation_unit_tb.sv -----
// ----------------------------------------------------------------------------
// temp_pressure_compensation_unit_tb
// self-checking bench for the temperature and pressure compensation unit
// ----------------------------------------------------------------------------
// Readings are queued by an initial block and sent by a clocked driver. A
// predictor runs the 32-bit integer compensation on every accepted reading and
// keeps the fine temperature of its own. A clocked monitor compares each result
// with the oldest prediction. Coefficients are changed between phases while the
// block is idle, and the phases vary the idling on both sides of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temp_pressure_compensation_unit_tb;
    import tpc_pkg::*;

    typedef struct packed {
        logic        func;
        logic [23:0] raw;
    } reading_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
    } comp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    reading_t     pending_readings[$];
    comp_result_t expected_results[$];

    logic [47:0] coef_temp;
    logic [63:0] coef_press_lo;
    logic [63:0] coef_press_hi;
    logic [15:0] coef_p9;
    logic [31:0] fine_temp;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  hold_cycles;
    int  error_count;
    int  idle_cycles;
    bit  drv_active;

    temp_pressure_compensation_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(logic [31:0] v, int n);
        return $signed(v) >>> n;
    endfunction

    function automatic comp_result_t compensate(reading_t rd);
        comp_result_t r;
        logic [31:0] adc, t1, t2, t3, v1, v2, d, sq, q, p, w1, w2;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        adc = {12'd0, rd.raw[23:4]};
        r = '0;
        r.kind = rd.func;
        if (rd.func == KIND_TEMP)
        begin
            t1 = {16'd0, coef_temp[15:0]};
            t2 = sext16(coef_temp[31:16]);
            t3 = sext16(coef_temp[47:32]);
            v1 = sra(((adc >> 3) - (t1 << 1)) * t2, 11);
            d = (adc >> 4) - t1;
            v2 = sra(sra(d * d, 12) * t3, 14);
            fine_temp = v1 + v2;
            r.temp_centi = sra(fine_temp * TEMP_SCALE + ROUND_HALF, 8);
        end
        else
        begin
            p1 = {16'd0, coef_press_lo[15:0]};
            p2 = sext16(coef_press_lo[31:16]);
            p3 = sext16(coef_press_lo[47:32]);
            p4 = sext16(coef_press_lo[63:48]);
            p5 = sext16(coef_press_hi[15:0]);
            p6 = sext16(coef_press_hi[31:16]);
            p7 = sext16(coef_press_hi[47:32]);
            p8 = sext16(coef_press_hi[63:48]);
            p9 = sext16(coef_p9);
            v1 = sra(fine_temp, 1) - FINE_OFFSET;
            q = sra(v1, 2);
            sq = q * q;
            v2 = sra(sq, 11) * p6;
            v2 = v2 + ((v1 * p5) << 1);
            v2 = sra(v2, 2) + (p4 << 16);
            v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
            v1 = sra((DIVS_OFFSET + v1) * p1, 15);
            if (v1 == 0)
                r.press_pa = 0;
            else
            begin
                p = ((ADC_FULL - adc) - sra(v2, 12)) * PRESS_SCALE;
                if (p < SIGN_BIT)
                    p = (p << 1) / v1;
                else
                    p = (p / v1) * 2;
                w1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
                w2 = sra((p >> 2) * p8, 13);
                r.press_pa = p + sra(w1 + w2 + p7, 4);
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(compensate({s_tuser, s_tdata}));
            if (!s_tvalid || s_tready)
            begin
                if (drv_active && pending_readings.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_readings[0].func;
                    s_tdata  <= pending_readings[0].raw;
                    void'(pending_readings.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall and monitor
    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t got;
        comp_result_t exp_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[31:0], m_tdata[63:32]};
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d actual %0d", exp_r.kind, got.kind);
                        error_count++;
                    end
                    if (got.temp_centi !== exp_r.temp_centi)
                    begin
                        $error("temperature_centi: expected %0d actual %0d",
                               $signed(exp_r.temp_centi), $signed(got.temp_centi));
                        error_count++;
                    end
                    if (got.press_pa !== exp_r.press_pa)
                    begin
                        $error("pressure_pa: expected %0d actual %0d",
                               exp_r.press_pa, got.press_pa);
                        error_count++;
                    end
                end
            end
            if (recv_hold && hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP:     coef_temp     = value[47:0];
            REG_PRESS_LO: coef_press_lo = value;
            REG_PRESS_HI: coef_press_hi = value;
            default:      coef_p9       = value[15:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        wait (pending_readings.size() == 0);
        do @(posedge clk); while (s_tvalid || expected_results.size() > 0);
        repeat (60) @(posedge clk);
    endtask

    // typical factory coefficients with small random spread
    task automatic write_typical();
        write_reg(REG_TEMP, 64'({16'hFC18 + 16'($urandom_range(200)),
                                 16'd26435 + 16'($urandom_range(400)),
                                 16'd27504 + 16'($urandom_range(400))}));
        write_reg(REG_PRESS_LO, {16'd2855, 16'hD0D0, 16'hD6D0,
                                 16'd36477 + 16'($urandom_range(500))});
        write_reg(REG_PRESS_HI, {16'd15500, 16'hFFF9, 16'hFFF9, 16'd140});
        write_reg(REG_PRESS_P9, 64'(16'd6000));
    endtask

    task automatic queue_readings(int n, bit typical);
        reading_t rd;
        repeat (n)
        begin
            rd.func = 1'($urandom_range(1));
            if (typical && $urandom_range(9) != 0)
                rd.raw = rd.func ? 24'h500000 + 24'($urandom_range(24'h300000))
                                 : 24'h700000 + 24'($urandom_range(24'h200000));
            else
                rd.raw = 24'($urandom);
            pending_readings.push_back(rd);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        coef_temp = '0;
        coef_press_lo = '0;
        coef_press_hi = '0;
        coef_p9 = '0;
        fine_temp = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        hold_cycles = 0;
        error_count = 0;
        idle_cycles = 0;
        drv_active = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero coefficients: pressure before any temperature, zero divisor
        pending_readings.push_back('{KIND_PRESS, 24'h000000});
        pending_readings.push_back('{KIND_PRESS, 24'hFFFFFF});
        pending_readings.push_back('{KIND_TEMP, 24'h000000});
        pending_readings.push_back('{KIND_TEMP, 24'hFFFFFF});
        drain();

        write_typical();
        pending_readings.push_back('{KIND_PRESS, 24'h65A3C0});
        pending_readings.push_back('{KIND_TEMP, 24'h7E5A20});
        pending_readings.push_back('{KIND_PRESS, 24'h65A3C0});
        pending_readings.push_back('{KIND_PRESS, 24'h000000});
        pending_readings.push_back('{KIND_PRESS, 24'hFFFFFF});
        pending_readings.push_back('{KIND_TEMP, 24'h00000F});
        pending_readings.push_back('{KIND_PRESS, 24'h800000});
        pending_readings.push_back('{KIND_TEMP, 24'hFFFFF0});
        pending_readings.push_back('{KIND_PRESS, 24'h7FFFFF});
        drain();

        // extreme coefficients for overflow and wraparound
        write_reg(REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_P9, 64'h0000_0000_0000_7FFF);
        pending_readings.push_back('{KIND_TEMP, 24'hFFFFFF});
        pending_readings.push_back('{KIND_PRESS, 24'h000000});
        pending_readings.push_back('{KIND_TEMP, 24'h000000});
        pending_readings.push_back('{KIND_PRESS, 24'hFFFFFF});
        drain();
        write_reg(REG_PRESS_P9, 64'hFFFF_FFFF_FFFF_8000);
        write_reg(REG_TEMP, 64'h8000_8000_0000);
        write_reg(REG_PRESS_LO, 64'h8000_8000_8000_0001);
        write_reg(REG_PRESS_HI, 64'h8000_8000_8000_8000);
        pending_readings.push_back('{KIND_TEMP, 24'h123456});
        pending_readings.push_back('{KIND_PRESS, 24'hABCDEF});
        pending_readings.push_back('{KIND_PRESS, 24'h555555});
        drain();

        // random phases with varied idling
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph == 5)
            begin
                write_reg(REG_TEMP, {$urandom, $urandom});
                write_reg(REG_PRESS_LO, {$urandom, $urandom});
                write_reg(REG_PRESS_HI, {$urandom, $urandom});
                write_reg(REG_PRESS_P9, {$urandom, $urandom});
            end
            else
                write_typical();
            if (ph == 4)
            begin
                hold_cycles = 400;
                recv_hold = 1'b1;
            end
            queue_readings(110, ph != 5);
            // sender pause until all results are in
            wait (pending_readings.size() < 50);
            drv_active = 1'b0;
            do @(posedge clk); while (s_tvalid || expected_results.size() > 0);
            drv_active = 1'b1;
            recv_hold = 1'b0;
            queue_readings(110, ph != 5);
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
